// ----- design/rlss_pkg.sv -----
package rlss_pkg;

    // Default depth of the pixel store.
    localparam int MAX_PIXELS_DEF = 256;

    // Field widths.
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int PCT_W      = 7;
    localparam int COUNT_W    = 9;
    localparam int POS_W      = 2;
    localparam int WORD_BITS  = 24;
    localparam int PHASE_W    = 4;
    localparam int BIT_W      = 5;

    // Configuration port.
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [REG_IDX_W-1:0] REG_LED_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RED_POS     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_POS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_POS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GLOBAL_PCT  = 3'd4;

    // Register reset values.
    localparam logic [COUNT_W-1:0] LED_COUNT_RST  = 9'd1;
    localparam logic [POS_W-1:0]   RED_POS_RST    = 2'd1;
    localparam logic [POS_W-1:0]   GREEN_POS_RST  = 2'd0;
    localparam logic [POS_W-1:0]   BLUE_POS_RST   = 2'd2;
    localparam logic [PCT_W-1:0]   GLOBAL_PCT_RST = 7'd50;

    // Bit timing in ticks.
    localparam logic [PHASE_W-1:0] BIT_TICKS = 4'd12;
    localparam logic [PHASE_W-1:0] ONE_HIGH  = 4'd8;
    localparam logic [PHASE_W-1:0] ZERO_HIGH = 4'd4;

    // Percent scaling: floor(v * pct / 100) is computed as
    // (v * ceil(pct * 2^16 / 100)) >> 16, exact for 8-bit v.
    localparam int PCT_FULL    = 100;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef logic [RECIP_W-1:0] pct_recip_t [PCT_FULL+1];

    function automatic pct_recip_t pct_recip_table();
        pct_recip_t tbl;
        for (int i = 0; i <= PCT_FULL; i++) begin
            tbl[i] = RECIP_W'((i * (1 << RECIP_SHIFT) + PCT_FULL - 1) / PCT_FULL);
        end
        return tbl;
    endfunction

    localparam pct_recip_t PCT_RECIP = pct_recip_table();

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] pixel_index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               use_global;
        logic [PCT_W-1:0]   pixel_brightness;
    } pixel_in_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } led_out_t;

endpackage

// ----- design/rgb_led_strip_serializer_core.sv -----
// RGB LED strip serializer: a pixel store and a one-wire bit-timing generator.
//
// The s_ channel carries one item per transfer (valid/ready). A write item scales
// red, green and blue by a percent brightness, orders the bytes by the configured
// wire positions and stores the word; a start item begins a frame of led_count
// pixels; a tick item advances the line by one time slot. Every item yields
// exactly one result transfer on the m_ channel: the line level for that tick,
// the busy flag after the item and a frame-done flag on the very last tick.
// Writes and starts are ignored while a frame is being sent.
//
// Throughput is one item per clock cycle while s_ready is high. Each result
// is registered into the output queue. The output queue holds two results,
// so an item is still taken while a result waits for m_ready; when both
// entries are full, s_ready drops until the receiver takes one.
//
// The next pixel of a frame is read from the store's read port while the
// current pixel shifts out, so the store has no read on the tick path.
//
// After reset every store address is swept to black in turn, during which
// s_ready is low. Configuration registers go to their reset values at once and
// the APB port accepts writes during the sweep.
module rgb_led_strip_serializer_core #(
    parameter int MAX_PIXELS = rlss_pkg::MAX_PIXELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rlss_pkg::pixel_in_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rlss_pkg::led_out_t                m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlss_pkg::PADDR_W-1:0]      paddr,
    input  logic [rlss_pkg::PDATA_W-1:0]      pwdata,
    output logic [rlss_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    // Address width of the store, and a counter width that holds both the
    // configured pixel count and the store depth itself.
    localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W = (PIX_W + 1 > rlss_pkg::COUNT_W) ? PIX_W + 1 : rlss_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] MAX_EXT = CNT_W'(MAX_PIXELS);
    localparam logic [PIX_W-1:0] LAST_ADDR = PIX_W'(MAX_PIXELS - 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [rlss_pkg::COUNT_W-1:0] led_count_reg;
    logic [rlss_pkg::POS_W-1:0]   red_pos_reg;
    logic [rlss_pkg::POS_W-1:0]   green_pos_reg;
    logic [rlss_pkg::POS_W-1:0]   blue_pos_reg;
    logic [rlss_pkg::PCT_W-1:0]   global_pct_reg;

    logic                            cfg_write;
    logic [rlss_pkg::REG_IDX_W-1:0]  cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[rlss_pkg::PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg  <= rlss_pkg::LED_COUNT_RST;
            red_pos_reg    <= rlss_pkg::RED_POS_RST;
            green_pos_reg  <= rlss_pkg::GREEN_POS_RST;
            blue_pos_reg   <= rlss_pkg::BLUE_POS_RST;
            global_pct_reg <= rlss_pkg::GLOBAL_PCT_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                rlss_pkg::REG_LED_COUNT:  led_count_reg  <= pwdata[rlss_pkg::COUNT_W-1:0];
                rlss_pkg::REG_RED_POS:    red_pos_reg    <= pwdata[rlss_pkg::POS_W-1:0];
                rlss_pkg::REG_GREEN_POS:  green_pos_reg  <= pwdata[rlss_pkg::POS_W-1:0];
                rlss_pkg::REG_BLUE_POS:   blue_pos_reg   <= pwdata[rlss_pkg::POS_W-1:0];
                rlss_pkg::REG_GLOBAL_PCT: global_pct_reg <= pwdata[rlss_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            rlss_pkg::REG_LED_COUNT:  prdata = rlss_pkg::PDATA_W'(led_count_reg);
            rlss_pkg::REG_RED_POS:    prdata = rlss_pkg::PDATA_W'(red_pos_reg);
            rlss_pkg::REG_GREEN_POS:  prdata = rlss_pkg::PDATA_W'(green_pos_reg);
            rlss_pkg::REG_BLUE_POS:   prdata = rlss_pkg::PDATA_W'(blue_pos_reg);
            rlss_pkg::REG_GLOBAL_PCT: prdata = rlss_pkg::PDATA_W'(global_pct_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------
    logic                            clearing_reg;
    logic [PIX_W-1:0]                clear_addr_reg;
    logic                            sending_reg,    sending_next;
    logic [PIX_W-1:0]                send_pixel_reg, send_pixel_next;
    logic [rlss_pkg::BIT_W-1:0]      send_bit_reg,   send_bit_next;
    logic [rlss_pkg::PHASE_W-1:0]    tick_phase_reg, tick_phase_next;
    logic [rlss_pkg::WORD_BITS-1:0]  shift_word_reg, shift_word_next;
    // Copy of pixel 0, so a start needs no store read.
    logic [rlss_pkg::WORD_BITS-1:0]  word0_reg;
    logic [1:0]                      out_cnt_reg;
    rlss_pkg::led_out_t              out_q_reg [2];

    logic in_xfer;
    logic out_xfer;

    assign s_ready  = !clearing_reg && (out_cnt_reg != 2'd2);
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = (out_cnt_reg != 2'd0);
    assign m_data   = out_q_reg[0];
    assign out_xfer = m_valid && m_ready;

    // ------------------------------------------------------------------
    // Write path: brightness scaling and byte placement.
    // ------------------------------------------------------------------
    logic [rlss_pkg::PCT_W-1:0]       pct_raw;
    logic [rlss_pkg::PCT_W-1:0]       pct_sat;
    logic [rlss_pkg::RECIP_W-1:0]     recip;
    logic [rlss_pkg::CHAN_W+rlss_pkg::RECIP_W-1:0] prod_r, prod_g, prod_b;
    logic [rlss_pkg::CHAN_W-1:0]      red_s, green_s, blue_s;
    logic [rlss_pkg::CHAN_W-1:0]      slot0, slot1, slot2;
    logic [rlss_pkg::WORD_BITS-1:0]   new_word;
    logic [CNT_W-1:0]                 idx_ext;
    logic                             idx_ok;

    assign pct_raw = s_data.use_global ? global_pct_reg : s_data.pixel_brightness;
    assign pct_sat = (pct_raw > rlss_pkg::PCT_W'(rlss_pkg::PCT_FULL))
                     ? rlss_pkg::PCT_W'(rlss_pkg::PCT_FULL) : pct_raw;
    assign recip   = rlss_pkg::PCT_RECIP[pct_sat];

    assign prod_r = (rlss_pkg::CHAN_W+rlss_pkg::RECIP_W)'(s_data.red)   * recip;
    assign prod_g = (rlss_pkg::CHAN_W+rlss_pkg::RECIP_W)'(s_data.green) * recip;
    assign prod_b = (rlss_pkg::CHAN_W+rlss_pkg::RECIP_W)'(s_data.blue)  * recip;

    assign red_s   = prod_r[rlss_pkg::RECIP_SHIFT +: rlss_pkg::CHAN_W];
    assign green_s = prod_g[rlss_pkg::RECIP_SHIFT +: rlss_pkg::CHAN_W];
    assign blue_s  = prod_b[rlss_pkg::RECIP_SHIFT +: rlss_pkg::CHAN_W];

    // Channels are placed in the order red, green, blue, so a later channel
    // wins a shared slot; position three drops the channel.
    always_comb begin
        slot0 = '0;
        slot1 = '0;
        slot2 = '0;
        if (red_pos_reg == 2'd0)   slot0 = red_s;
        if (red_pos_reg == 2'd1)   slot1 = red_s;
        if (red_pos_reg == 2'd2)   slot2 = red_s;
        if (green_pos_reg == 2'd0) slot0 = green_s;
        if (green_pos_reg == 2'd1) slot1 = green_s;
        if (green_pos_reg == 2'd2) slot2 = green_s;
        if (blue_pos_reg == 2'd0)  slot0 = blue_s;
        if (blue_pos_reg == 2'd1)  slot1 = blue_s;
        if (blue_pos_reg == 2'd2)  slot2 = blue_s;
    end

    assign new_word = {slot0, slot1, slot2};
    assign idx_ext  = CNT_W'(s_data.pixel_index);
    assign idx_ok   = idx_ext < MAX_EXT;

    // ------------------------------------------------------------------
    // Pixel store: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [rlss_pkg::WORD_BITS-1:0] pixel_mem [MAX_PIXELS];
    logic [rlss_pkg::WORD_BITS-1:0] mem_rdata_reg;
    logic                           mem_we;
    logic [PIX_W-1:0]               mem_waddr;
    logic [rlss_pkg::WORD_BITS-1:0] mem_wdata;
    logic [PIX_W-1:0]               mem_raddr;
    logic                           pix_write;

    assign pix_write = in_xfer && (s_data.func == rlss_pkg::FUNC_WRITE)
                       && !sending_reg && idx_ok;
    assign mem_we    = clearing_reg || pix_write;
    assign mem_waddr = clearing_reg ? clear_addr_reg : idx_ext[PIX_W-1:0];
    assign mem_wdata = clearing_reg ? '0 : new_word;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pixel_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= pixel_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Serializer.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]             led_ext;
    logic [CNT_W-1:0]             frame_len;
    logic [CNT_W-1:0]             next_pix;
    logic                         last_pixel;
    logic [rlss_pkg::PHASE_W-1:0] high_ticks;
    rlss_pkg::led_out_t           res;

    assign led_ext    = CNT_W'(led_count_reg);
    assign frame_len  = (led_ext > MAX_EXT) ? MAX_EXT : led_ext;
    assign next_pix   = CNT_W'(send_pixel_reg) + CNT_W'(1);
    assign last_pixel = next_pix >= frame_len;
    // Prefetch the pixel after the current one; the store is frozen while
    // sending, so the data has long settled by the end of the pixel.
    assign mem_raddr  = (next_pix < MAX_EXT) ? next_pix[PIX_W-1:0] : '0;
    assign high_ticks = shift_word_reg[rlss_pkg::WORD_BITS-1]
                        ? rlss_pkg::ONE_HIGH : rlss_pkg::ZERO_HIGH;

    always_comb begin
        sending_next    = sending_reg;
        send_pixel_next = send_pixel_reg;
        send_bit_next   = send_bit_reg;
        tick_phase_next = tick_phase_reg;
        shift_word_next = shift_word_reg;
        res             = '0;
        if (in_xfer) begin
            unique case (s_data.func)
                rlss_pkg::FUNC_START: begin
                    if (!sending_reg && (frame_len != '0)) begin
                        sending_next    = 1'b1;
                        send_pixel_next = '0;
                        send_bit_next   = '0;
                        tick_phase_next = '0;
                        shift_word_next = word0_reg;
                    end
                end
                rlss_pkg::FUNC_TICK: begin
                    if (sending_reg) begin
                        res.line_level  = tick_phase_reg < high_ticks;
                        tick_phase_next = tick_phase_reg + 1'b1;
                        if (tick_phase_reg == rlss_pkg::BIT_TICKS - 1'b1) begin
                            tick_phase_next = '0;
                            shift_word_next = {shift_word_reg[rlss_pkg::WORD_BITS-2:0], 1'b0};
                            send_bit_next   = send_bit_reg + 1'b1;
                            if (send_bit_reg == rlss_pkg::BIT_W'(rlss_pkg::WORD_BITS - 1)) begin
                                send_bit_next = '0;
                                if (last_pixel) begin
                                    sending_next    = 1'b0;
                                    send_pixel_next = '0;
                                    shift_word_next = '0;
                                    res.frame_done  = 1'b1;
                                end else begin
                                    send_pixel_next = next_pix[PIX_W-1:0];
                                    shift_word_next = mem_rdata_reg;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        res.busy_res = sending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            sending_reg    <= 1'b0;
            send_pixel_reg <= '0;
            send_bit_reg   <= '0;
            tick_phase_reg <= '0;
            shift_word_reg <= '0;
            word0_reg      <= '0;
            out_cnt_reg    <= 2'd0;
        end else begin
            if (clearing_reg) begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == LAST_ADDR) begin
                    clearing_reg <= 1'b0;
                end
            end
            sending_reg    <= sending_next;
            send_pixel_reg <= send_pixel_next;
            send_bit_reg   <= send_bit_next;
            tick_phase_reg <= tick_phase_next;
            shift_word_reg <= shift_word_next;
            if (pix_write && (idx_ext == '0)) begin
                word0_reg <= new_word;
            end
            if (in_xfer && !out_xfer) begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end else if (out_xfer && !in_xfer) begin
                out_cnt_reg <= out_cnt_reg - 1'b1;
            end
        end
    end

    // Two-entry output queue; entry 0 is the head.
    always_ff @(posedge aclk) begin
        if (in_xfer && out_xfer) begin
            if (out_cnt_reg == 2'd2) begin
                out_q_reg[0] <= out_q_reg[1];
                out_q_reg[1] <= res;
            end else begin
                out_q_reg[0] <= res;
            end
        end else if (in_xfer) begin
            if (out_cnt_reg == 2'd0) begin
                out_q_reg[0] <= res;
            end else begin
                out_q_reg[1] <= res;
            end
        end else if (out_xfer) begin
            out_q_reg[0] <= out_q_reg[1];
        end
    end

endmodule

// ----- design/rlss_checker.sv -----
module rlss_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rlss_pkg::led_out_t m_data
);

    // The store sweep keeps the input closed right after reset.
    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during the store sweep after reset");

    // The line is only driven high while a frame is in progress.
    a_level_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.line_level) |-> m_data.busy_res)
        else $error("line high outside a frame");

    // The end of a frame leaves the block idle, and that last slot is low.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> (!m_data.busy_res && !m_data.line_level))
        else $error("frame done while still busy or driving high");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule

bind rgb_led_strip_serializer_core rlss_checker u_rlss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
